/* hdl/e8ld_pkg.sv */
// Shared constants for the E8 lattice block decoder.
// No dependencies; imported by e8ld_pair_decide and the top level.
`default_nettype none

package e8ld_pkg;

  localparam int COEF_W     = 11;
  localparam int BLOCK_LEN  = 8;
  localparam int PAIR_COUNT = 4;
  localparam int PAIR_IDX_W = 2;
  localparam int NIBBLE_W   = 4;
  localparam int S_TDATA_W  = COEF_W * BLOCK_LEN;   // 88, already whole bytes
  localparam int M_TDATA_W  = 8;

  // Coset selectors: coset 0 is D8 itself, coset 1 is D8 shifted by QHAT/2 on even coords
  localparam logic COSET_ZERO = 1'b0;
  localparam logic COSET_ONE  = 1'b1;

  typedef logic [PAIR_COUNT-1:0] labels_t;
  typedef logic [NIBBLE_W-1:0]   nibble_t;

endpackage

`default_nettype wire

/* hdl/e8_lattice_block_decoder_unit.sv */
// E8 lattice block decoder: top level, five-stage pipeline.
// Depends on e8ld_pkg and e8ld_pair_decide.
//
// Usage:
//   Slave channel (s_*) carries one block of eight coefficients per beat.
//   Only the low QHAT_BITS bits of each coefficient are used (all 11 when
//   QHAT_BITS >= 11). Master channel (m_*) returns one decoded nibble per
//   block: bit 0 is the winning coset, bits 1..3 come from its pair labels.
//   Stages: 1 fold residues to distances, 2 square, 3 pair labels for both
//   cosets, 4 sum costs / parity / smallest delta, 5 parity fix, coset pick
//   and output register.
//   Throughput: one block per cycle while the output is not stalled; the
//   critical path is one QHAT_BITS x QHAT_BITS multiply (11x11 by default)
//   or one wide add and compare per stage.
//   Stalls: each stage holds while the one after it is full and blocked;
//   bubbles collapse, so s_tready stays high while a free slot exists, even
//   while an output beat waits for m_tready.
//   Reset (rst, synchronous, active high) empties the pipeline; no payload
//   state survives or matters. Blocks are independent of each other.
`default_nettype none

module e8_lattice_block_decoder_unit
  import e8ld_pkg::*;
#(
  parameter int QHAT_BITS = 11
) (
  input  logic                 clk,
  input  logic                 rst,
  // slave side: coef0 [10:0], coef1 [21:11], ... coef7 [87:77]
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,
  // master side: nibble [3:0], zeros [7:4]
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata
);

  localparam int VW    = QHAT_BITS;     // residue / distance width
  localparam int SQ_W  = 2 * VW - 1;    // squared distance, max 2^(2VW-2)
  localparam int PW    = 2 * VW;        // pair cost
  localparam int TW    = 2 * VW + 2;    // block cost
  localparam logic [VW-1:0] HALF = {1'b1, {(VW-1){1'b0}}};

  // ---------------- stage handshake ----------------
  logic v1, v2, v3, v4;
  logic adv1, adv2, adv3, adv4, adv5;

  assign adv5     = !m_tvalid || m_tready;
  assign adv4     = !v4 || adv5;
  assign adv3     = !v3 || adv4;
  assign adv2     = !v2 || adv3;
  assign adv1     = !v1 || adv2;
  assign s_tready = adv1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v2       <= 1'b0;
      v3       <= 1'b0;
      v4       <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (adv1) v1 <= s_tvalid;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
      if (adv4) v4 <= v3;
      if (adv5) m_tvalid <= v4;
    end
  end

  // ---------------- stage 1: distances ----------------
  // a: cyclic distance to 0, b: distance to QHAT/2
  logic [VW-1:0] a_c  [BLOCK_LEN];
  logic [VW-1:0] b_c  [BLOCK_LEN];
  logic [VW-1:0] a_s1 [BLOCK_LEN];
  logic [VW-1:0] b_s1 [BLOCK_LEN];

  always_comb begin
    logic [VW-1:0] res;
    for (int i = 0; i < BLOCK_LEN; i++) begin
      res    = VW'(s_tdata[i*COEF_W +: COEF_W]);
      a_c[i] = res[VW-1] ? (~res + VW'(1)) : res;
      b_c[i] = res[VW-1] ? (res & ~HALF) : (HALF - res);
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      for (int i = 0; i < BLOCK_LEN; i++) begin
        a_s1[i] <= a_c[i];
        b_s1[i] <= b_c[i];
      end
    end
  end

  // ---------------- stage 2: squares ----------------
  logic [SQ_W-1:0] d0_s2 [BLOCK_LEN];
  logic [SQ_W-1:0] d1_s2 [BLOCK_LEN];

  always_ff @(posedge clk) begin
    logic [PW-1:0] sq_a;
    logic [PW-1:0] sq_b;
    if (adv2) begin
      for (int i = 0; i < BLOCK_LEN; i++) begin
        sq_a     = PW'(a_s1[i]) * PW'(a_s1[i]);
        sq_b     = PW'(b_s1[i]) * PW'(b_s1[i]);
        d0_s2[i] <= sq_a[SQ_W-1:0];
        d1_s2[i] <= sq_b[SQ_W-1:0];
      end
    end
  end

  // ---------------- stage 3: pair labels, both cosets ----------------
  logic          lab_c    [2][PAIR_COUNT];
  logic [PW-1:0] chosen_c [2][PAIR_COUNT];
  logic [PW-1:0] delta_c  [2][PAIR_COUNT];

  logic          lab_s3    [2][PAIR_COUNT];
  logic [PW-1:0] chosen_s3 [2][PAIR_COUNT];
  logic [PW-1:0] delta_s3  [2][PAIR_COUNT];

  for (genvar c = 0; c < 2; c++) begin : g_coset
    for (genvar p = 0; p < PAIR_COUNT; p++) begin : g_pair
      e8ld_pair_decide #(
        .QHAT_BITS (QHAT_BITS)
      ) u_pair (
        .coset   ((c == 1) ? COSET_ONE : COSET_ZERO),
        .d0_even (d0_s2[2*p]),
        .d1_even (d1_s2[2*p]),
        .d0_odd  (d0_s2[2*p+1]),
        .d1_odd  (d1_s2[2*p+1]),
        .label   (lab_c[c][p]),
        .chosen  (chosen_c[c][p]),
        .delta   (delta_c[c][p])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (adv3) begin
      for (int c = 0; c < 2; c++) begin
        for (int p = 0; p < PAIR_COUNT; p++) begin
          lab_s3[c][p]    <= lab_c[c][p];
          chosen_s3[c][p] <= chosen_c[c][p];
          delta_s3[c][p]  <= delta_c[c][p];
        end
      end
    end
  end

  // ---------------- stage 4: cost sum, parity, smallest delta ----------------
  logic [TW-1:0]         total_c [2];
  labels_t               labs_c  [2];
  logic [PW-1:0]         best_c  [2];
  logic [PAIR_IDX_W-1:0] bp_c    [2];

  always_comb begin
    for (int c = 0; c < 2; c++) begin
      total_c[c] = '0;
      best_c[c]  = delta_s3[c][0];
      bp_c[c]    = '0;
      for (int p = 0; p < PAIR_COUNT; p++) begin
        labs_c[c][p] = lab_s3[c][p];
        total_c[c]   = total_c[c] + TW'(chosen_s3[c][p]);
      end
      // strict compare: lowest pair wins a delta tie
      for (int p = 1; p < PAIR_COUNT; p++) begin
        if (delta_s3[c][p] < best_c[c]) begin
          best_c[c] = delta_s3[c][p];
          bp_c[c]   = PAIR_IDX_W'(p);
        end
      end
    end
  end

  logic [TW-1:0]         total_s4 [2];
  labels_t               labs_s4  [2];
  logic                  par_s4   [2];
  logic [PW-1:0]         best_s4  [2];
  logic [PAIR_IDX_W-1:0] bp_s4    [2];

  always_ff @(posedge clk) begin
    if (adv4) begin
      for (int c = 0; c < 2; c++) begin
        total_s4[c] <= total_c[c];
        labs_s4[c]  <= labs_c[c];
        par_s4[c]   <= ^labs_c[c];
        best_s4[c]  <= best_c[c];
        bp_s4[c]    <= bp_c[c];
      end
    end
  end

  // ---------------- stage 5: parity fix, coset pick, output ----------------
  logic [TW-1:0] cost_f [2];
  labels_t       labs_f [2];
  logic          pick;
  labels_t       win;
  nibble_t       nibble;

  always_comb begin
    for (int c = 0; c < 2; c++) begin
      // odd parity: flip the cheapest pair back to a valid D8 point
      cost_f[c] = total_s4[c] + (par_s4[c] ? TW'(best_s4[c]) : TW'(0));
      labs_f[c] = labs_s4[c] ^ (par_s4[c] ? (labels_t'(1) << bp_s4[c]) : labels_t'(0));
    end
    pick   = (cost_f[1] < cost_f[0]) ? COSET_ONE : COSET_ZERO;   // tie -> coset 0
    win    = (pick == COSET_ONE) ? labs_f[1] : labs_f[0];
    nibble = {win[3], win[1] ^ win[0], win[0], pick};
  end

  always_ff @(posedge clk) begin
    if (adv5) begin
      m_tdata <= {{(M_TDATA_W-NIBBLE_W){1'b0}}, nibble};
    end
  end

`ifndef SYNTHESIS
  // full pipeline behind a stalled output must refuse new beats
  assert property (@(posedge clk) disable iff (rst)
    (v1 && v2 && v3 && v4 && m_tvalid && !m_tready) |-> !s_tready)
    else $error("s_tready high with pipeline full and output stalled");

  // a blocked stage 4 keeps its block
  assert property (@(posedge clk) disable iff (rst)
    (v4 && !adv5) |=> (v4 && $stable(total_s4[0]) && $stable(total_s4[1])))
    else $error("stage 4 lost or changed a block while stalled");

  // an accepted beat always lands in stage 1
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> v1)
    else $error("accepted input beat did not enter stage 1");
`endif

endmodule

`default_nettype wire

/* hdl/e8ld_pair_decide.sv */
// Label decision for one coordinate pair of a D8 decode.
// Depends on e8ld_pkg (coset codes).
`default_nettype none

module e8ld_pair_decide
  import e8ld_pkg::*;
#(
  parameter int QHAT_BITS = 11
) (
  input  logic                     coset,
  input  logic [2*QHAT_BITS-2:0]   d0_even,
  input  logic [2*QHAT_BITS-2:0]   d1_even,
  input  logic [2*QHAT_BITS-2:0]   d0_odd,
  input  logic [2*QHAT_BITS-2:0]   d1_odd,
  output logic                     label,
  output logic [2*QHAT_BITS-1:0]   chosen,
  output logic [2*QHAT_BITS-1:0]   delta
);

  localparam int PW = 2 * QHAT_BITS;

  logic [PW-1:0] cost_l0;
  logic [PW-1:0] cost_l1;

  // coset 1 swaps the even coordinate's two targets
  always_comb begin
    if (coset == COSET_ONE) begin
      cost_l0 = PW'(d1_even) + PW'(d0_odd);
      cost_l1 = PW'(d0_even) + PW'(d1_odd);
    end else begin
      cost_l0 = PW'(d0_even) + PW'(d0_odd);
      cost_l1 = PW'(d1_even) + PW'(d1_odd);
    end
  end

  // label 0 kept on a tie
  always_comb begin
    if (cost_l1 < cost_l0) begin
      label  = 1'b1;
      chosen = cost_l1;
      delta  = cost_l0 - cost_l1;
    end else begin
      label  = 1'b0;
      chosen = cost_l0;
      delta  = cost_l1 - cost_l0;
    end
  end

endmodule

`default_nettype wire
